FILE: hw/rtl/cdpq_pkg.sv
// Package for the category/date priority queue: record and beat types, opcodes and codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cdpq_pkg;
  localparam int CAPACITY_DEF = 16;
  localparam int TAG_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_PEEK  = 2'd1,
    OP_POP   = 2'd2,
    OP_COUNT = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_SPARE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  category;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] tag;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  out_priority;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [15:0] out_tag;
    logic [15:0] out_arrival;
    logic [4:0]  entry_count;
  } out_beat_t;

  // Stored record; the key fields sit high so that one compare ranks them.
  typedef struct packed {
    logic [2:0]  prio;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] tag;
    logic [15:0] arrival;
  } rec_t;

  function automatic logic [2:0] prio_of_kind(input logic [2:0] kind);
    logic [2:0] p;
    unique case (kind)
      3'd0: p = 3'd5;
      3'd1: p = 3'd4;
      3'd2: p = 3'd3;
      3'd3: p = 3'd2;
      default: p = 3'd1;
    endcase
    return p;
  endfunction

  // True when a outranks b: higher priority, later date, then earlier arrival.
  function automatic logic outranks(input rec_t a, input rec_t b);
    logic r;
    if ({a.prio, a.year, a.month, a.day} != {b.prio, b.year, b.month, b.day}) begin
      r = {a.prio, a.year, a.month, a.day} > {b.prio, b.year, b.month, b.day};
    end else begin
      r = a.arrival < b.arrival;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/category_date_priority_queue_core.sv
// Top level of the category/date priority queue: command sequencer around the entry memory.
// Depends on cdpq_pkg and cdpq_store.
//
// Usage: drive in_beat and raise start while busy is low; that beat is taken.
// Exactly one result beat follows on out_beat, marked by out_valid for one cycle.
// Peek and pop scan the held entries through the single read port of the
// entry memory, one entry per cycle; a pop then reads the last held entry
// and writes it into the vacated slot. busy stays high through the result
// beat, so the next beat is not taken until the result beat has been shown.
// Reset empties the queue and clears the arrival counter; memory contents are
// not cleared, since only data read from slots below the held count is ever used.
// The receiver cannot stall; each result beat is shown for one cycle only.
`timescale 1ns / 1ps
`default_nettype none
module category_date_priority_queue_core #(
  parameter int CAPACITY = cdpq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = cdpq_pkg::TAG_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire cdpq_pkg::in_beat_t  in_beat,
  output logic                     out_valid,
  output cdpq_pkg::out_beat_t      out_beat
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_LAST = 6'b000100,
    S_MOVE = 6'b001000,
    S_DONE = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0] arr_r, arr_nxt;
  logic [1:0] op_r, op_nxt;
  logic [CW-1:0] idx_r, idx_nxt;     // slot being read
  logic [CW-1:0] cmp_r, cmp_nxt;     // slot whose data is arriving
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  cdpq_pkg::rec_t best_r, best_nxt;
  cdpq_pkg::out_beat_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  cdpq_pkg::rec_t wr_data, rd_data, push_rec;
  logic [15:0] tag_kept;

  cdpq_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  assign tag_kept = in_beat.tag & 16'((17'd1 << TAG_BITS) - 17'd1);

  always_comb begin
    push_rec.prio    = cdpq_pkg::prio_of_kind(in_beat.category);
    push_rec.year    = in_beat.year;
    push_rec.month   = in_beat.month;
    push_rec.day     = in_beat.day;
    push_rec.tag     = tag_kept;
    push_rec.arrival = arr_r;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    arr_nxt = arr_r;
    op_nxt = op_r;
    idx_nxt = idx_r;
    cmp_nxt = cmp_r;
    best_idx_nxt = best_idx_r;
    best_nxt = best_r;
    res_nxt = res_r;
    out_valid_nxt = 1'b0;
    wr_en = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = push_rec;
    rd_addr = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        // The cycle that shows a result beat still counts as busy.
        if (start && !out_valid_r) begin
          op_nxt = in_beat.opcode;
          res_nxt = '0;
          unique case (in_beat.opcode)
            cdpq_pkg::OP_PUSH: begin
              if (count_r >= CW'(CAPACITY)) begin
                res_nxt.status = cdpq_pkg::ST_FULL;
              end else begin
                wr_en = 1'b1;
                arr_nxt = arr_r + 16'd1;
                count_nxt = count_r + CW'(1);
              end
              state_nxt = S_OUT;
            end
            cdpq_pkg::OP_COUNT: state_nxt = S_OUT;
            default: begin
              if (count_r == '0) begin
                res_nxt.status = cdpq_pkg::ST_EMPTY;
                state_nxt = S_OUT;
              end else begin
                rd_addr = '0;
                idx_nxt = CW'(1);
                cmp_nxt = '0;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // rd_data holds slot cmp_r; slot idx_r is being read.
        if (cmp_r == '0 || cdpq_pkg::outranks(rd_data, best_r)) begin
          best_nxt = rd_data;
          best_idx_nxt = cmp_r[AW-1:0];
        end
        cmp_nxt = idx_r;
        idx_nxt = idx_r + CW'(1);
        if (idx_r >= count_r) begin
          state_nxt = S_LAST;
          rd_addr = AW'(count_r - CW'(1));
        end
      end
      S_LAST: begin
        // Last compare was done; now rd_data is the last held slot.
        if (op_r == cdpq_pkg::OP_POP) begin
          state_nxt = S_MOVE;
        end else begin
          state_nxt = S_DONE;
        end
        rd_addr = AW'(count_r - CW'(1));
      end
      S_MOVE: begin
        wr_en = 1'b1;
        wr_addr = best_idx_r;
        wr_data = rd_data;
        count_nxt = count_r - CW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_nxt.out_priority = best_r.prio;
        res_nxt.out_year = best_r.year;
        res_nxt.out_month = best_r.month;
        res_nxt.out_day = best_r.day;
        res_nxt.out_tag = best_r.tag;
        res_nxt.out_arrival = best_r.arrival;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res_nxt.entry_count = 5'(count_r);
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      arr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      arr_r <= arr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;
    idx_r <= idx_nxt;
    cmp_r <= cmp_nxt;
    best_idx_r <= best_idx_nxt;
    best_r <= best_nxt;
    res_r <= res_nxt;
  end

  assign busy = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_beat = res_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("held count beyond capacity");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result beat held for two cycles");
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status == cdpq_pkg::ST_FULL |-> count_r == CW'(CAPACITY))
    else $error("full status with room left");
  a_move_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE |-> op_r == cdpq_pkg::OP_POP && count_r != '0)
    else $error("slot move outside a pop");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/cdpq_store.sv
// Entry memory of the priority queue: one write port, one registered read port.
// Depends on cdpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdpq_store #(
  parameter int CAPACITY = cdpq_pkg::CAPACITY_DEF,
  parameter int AW = $clog2(CAPACITY)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire cdpq_pkg::rec_t  wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output cdpq_pkg::rec_t       rd_data
);
  cdpq_pkg::rec_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: test/tb_category_date_priority_queue_core.sv
// Self-checking testbench for the category/date priority queue core.
// Depends on cdpq_pkg and category_date_priority_queue_core; drives commands, checks result beats.
`timescale 1ns / 1ps
module tb_category_date_priority_queue_core;
  localparam int QCAP = cdpq_pkg::CAPACITY_DEF;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [2:0]  prio;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] tag;
    logic [15:0] arrival;
  } held_rec_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  cdpq_pkg::in_beat_t  in_beat;
  logic                out_valid;
  cdpq_pkg::out_beat_t out_beat;

  category_date_priority_queue_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_valid(out_valid), .out_beat(out_beat)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Predictor state.
  held_rec_t model_slots[QCAP];
  int        model_held;
  logic [15:0] model_arrival;

  cdpq_pkg::in_beat_t  pending_cmds[$];
  cdpq_pkg::out_beat_t expected_results[$];
  bit        stim_done;
  bit        hold_sender;
  bit        quiet_sender;
  int        fail_count;
  int        idle_cycles;
  int        gap_left;

  function automatic bit beats(held_rec_t a, held_rec_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    if (a.year != b.year) return a.year > b.year;
    if (a.month != b.month) return a.month > b.month;
    if (a.day != b.day) return a.day > b.day;
    return a.arrival < b.arrival;
  endfunction

  function automatic cdpq_pkg::out_beat_t queue_step(cdpq_pkg::in_beat_t cmd);
    cdpq_pkg::out_beat_t r;
    held_rec_t rec;
    int best;
    r = '0;
    case (cdpq_pkg::opcode_t'(cmd.opcode))
      cdpq_pkg::OP_PUSH: begin
        if (model_held >= QCAP) begin
          r.status = cdpq_pkg::ST_FULL;
        end else begin
          case (cmd.category)
            3'd0: rec.prio = 3'd5;
            3'd1: rec.prio = 3'd4;
            3'd2: rec.prio = 3'd3;
            3'd3: rec.prio = 3'd2;
            default: rec.prio = 3'd1;
          endcase
          rec.year = cmd.year;
          rec.month = cmd.month;
          rec.day = cmd.day;
          rec.tag = cmd.tag;
          rec.arrival = model_arrival;
          model_slots[model_held] = rec;
          model_arrival = model_arrival + 16'd1;
          model_held++;
        end
      end
      cdpq_pkg::OP_PEEK, cdpq_pkg::OP_POP: begin
        if (model_held == 0) begin
          r.status = cdpq_pkg::ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < model_held; i++)
            if (beats(model_slots[i], model_slots[best])) best = i;
          r.out_priority = model_slots[best].prio;
          r.out_year = model_slots[best].year;
          r.out_month = model_slots[best].month;
          r.out_day = model_slots[best].day;
          r.out_tag = model_slots[best].tag;
          r.out_arrival = model_slots[best].arrival;
          if (cmd.opcode == cdpq_pkg::OP_POP) begin
            model_held--;
            model_slots[best] = model_slots[model_held];
          end
        end
      end
      default: ;
    endcase
    r.entry_count = model_held[4:0];
    return r;
  endfunction

  function automatic cdpq_pkg::in_beat_t make_cmd(cdpq_pkg::opcode_t op, bit wild);
    cdpq_pkg::in_beat_t c;
    c.opcode = op;
    c.category = wild ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
    // Narrow year/date ranges make date ties common, so arrival order gets exercised.
    case ($urandom_range(0, 3))
      0: c.year = 14'($urandom);
      1: c.year = 14'($urandom_range(2020, 2022));
      default: c.year = 14'($urandom_range(0, 9999));
    endcase
    c.month = wild ? 4'($urandom) : 4'($urandom_range(1, 12));
    c.day = wild ? 5'($urandom) : 5'($urandom_range(1, 31));
    if ($urandom_range(0, 3) == 0) begin
      c.month = 4'd6;
      c.day = 5'd15;
    end
    c.tag = 16'($urandom);
    return c;
  endfunction

  // Driver: one command at a time, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_beat <= '0;
      gap_left <= 0;
    end else if (start && !busy) begin
      start <= 1'b0;
      gap_left <= quiet_sender ? 0 : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 10) : 0);
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() > 0 && !hold_sender) begin
        in_beat <= pending_cmds.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Prediction happens when the command beat is taken.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      expected_results.push_back(queue_step(in_beat));
  end

  // Monitor.
  always @(posedge clk) begin
    cdpq_pkg::out_beat_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_beat.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_beat.status); fail_count++;
        end
        if (out_beat.out_priority !== want.out_priority) begin
          $error("out_priority exp %0d got %0d", want.out_priority, out_beat.out_priority);
          fail_count++;
        end
        if (out_beat.out_year !== want.out_year) begin
          $error("out_year exp %0d got %0d", want.out_year, out_beat.out_year); fail_count++;
        end
        if (out_beat.out_month !== want.out_month) begin
          $error("out_month exp %0d got %0d", want.out_month, out_beat.out_month); fail_count++;
        end
        if (out_beat.out_day !== want.out_day) begin
          $error("out_day exp %0d got %0d", want.out_day, out_beat.out_day); fail_count++;
        end
        if (out_beat.out_tag !== want.out_tag) begin
          $error("out_tag exp %0h got %0h", want.out_tag, out_beat.out_tag); fail_count++;
        end
        if (out_beat.out_arrival !== want.out_arrival) begin
          $error("out_arrival exp %0d got %0d", want.out_arrival, out_beat.out_arrival);
          fail_count++;
        end
        if (out_beat.entry_count !== want.entry_count) begin
          $error("entry_count exp %0d got %0d", want.entry_count, out_beat.entry_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("category_date_priority_queue_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    cdpq_pkg::in_beat_t c;
    int want_held;
    rst_n = 1'b0;
    start = 1'b0;
    in_beat = '0;
    stim_done = 1'b0;
    hold_sender = 1'b0;
    quiet_sender = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    gap_left = 0;
    model_held = 0;
    model_arrival = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue, field extremes, unknown categories, odd dates, full queue.
    c = '0;
    c.opcode = cdpq_pkg::OP_PEEK;  pending_cmds.push_back(c);
    c.opcode = cdpq_pkg::OP_POP;   pending_cmds.push_back(c);
    c.opcode = cdpq_pkg::OP_COUNT; pending_cmds.push_back(c);
    for (int k = 0; k < 8; k++) begin
      c = '0;
      c.opcode = cdpq_pkg::OP_PUSH;
      c.category = 3'(k);
      c.year = (k % 2) ? 14'h3FFF : 14'd0;
      c.month = (k % 2) ? 4'hF : 4'd0;
      c.day = (k % 2) ? 5'h1F : 5'd0;
      c.tag = (k % 2) ? 16'hFFFF : 16'h0000;
      pending_cmds.push_back(c);
    end
    for (int k = 0; k < 9; k++) pending_cmds.push_back(make_cmd(cdpq_pkg::OP_PUSH, 1));
    c = '0;
    c.opcode = cdpq_pkg::OP_PEEK;  pending_cmds.push_back(c);
    c.opcode = cdpq_pkg::OP_COUNT; pending_cmds.push_back(c);
    for (int k = 0; k < 3; k++) begin
      c.opcode = cdpq_pkg::OP_POP; pending_cmds.push_back(c);
    end

    // Random part: fill/drain swings so full and empty are both hit often.
    want_held = 13;
    for (int n = 0; n < 1800; n++) begin
      if (n % 300 == 150) begin
        // Let the sender wait until everything outstanding has come back.
        wait (pending_cmds.size() == 0);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0 && !start);
        hold_sender = 1'b0;
      end
      if (n == 1500) quiet_sender = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c = make_cmd(cdpq_pkg::OP_PUSH, $urandom_range(0, 7) == 0);
        4: c = make_cmd(cdpq_pkg::OP_PEEK, 1);
        5, 6, 7, 8: c = make_cmd(cdpq_pkg::OP_POP, 1);
        default: c = make_cmd(cdpq_pkg::OP_COUNT, 1);
      endcase
      if ((n / 60) % 2 == 0 && $urandom_range(0, 1) == 0) c.opcode = cdpq_pkg::OP_PUSH;
      pending_cmds.push_back(c);
    end

    wait (pending_cmds.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("category_date_priority_queue_core verification clean");
    end else begin
      $display("category_date_priority_queue_core verification failed");
    end
    $finish;
  end
endmodule
